// ----- rtl/ksa_pkg.sv -----
// Shared constants, types and codes for the kernel splat accumulator.
// Used by ksa_window and kernel_splat_accumulator; depends on nothing else.

package ksa_pkg;

  // Grid and stamp geometry
  localparam int GRID_WIDTH   = 256;
  localparam int GRID_HEIGHT  = 256;
  localparam int STAMP_RADIUS = 16;

  localparam int STAMP_SIDE  = 2 * STAMP_RADIUS;
  localparam int GRID_CELLS  = GRID_WIDTH * GRID_HEIGHT;
  localparam int STAMP_CELLS = STAMP_SIDE * STAMP_SIDE;
  localparam int SWEEP_CELLS = (GRID_CELLS > STAMP_CELLS) ? GRID_CELLS : STAMP_CELLS;

  localparam int GAW = $clog2(GRID_CELLS);
  localparam int SAW = $clog2(STAMP_CELLS);
  localparam int SWW = $clog2(SWEEP_CELLS);
  localparam int SCW = $clog2(STAMP_SIDE);

  // Coordinate width: enough for any 8-bit position plus the radius, and for the grid edge
  localparam int CMAX_W = (GRID_WIDTH > 256) ? GRID_WIDTH : 256;
  localparam int CMAX_H = (GRID_HEIGHT > CMAX_W) ? GRID_HEIGHT : CMAX_W;
  localparam int CW     = $clog2(CMAX_H + STAMP_RADIUS + 1);

  localparam int POS_W   = 8;
  localparam int SIDX_W  = 5;
  localparam int VAL_W   = 8;

  localparam int IN_DATA_W  = 40;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 8;
  localparam int OUT_USER_W = 1;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_ADD   = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_CLEAR,
    ST_IDLE,
    ST_SPLAT,
    ST_READ,
    ST_DONE
  } state_t;

  // One access of the splat window: grid cell and the stamp entry that lands on it
  typedef struct packed {
    logic           valid;
    logic           last;
    logic [GAW-1:0] gaddr;
    logic [SAW-1:0] saddr;
  } win_acc_t;

endpackage

// ----- rtl/ksa_window.sv -----
// Splat window walker: clips the stamp window to the grid and steps through it,
// one grid cell and matching stamp entry per cycle. Depends on ksa_pkg.

module ksa_window import ksa_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [POS_W-1:0] pos_x,
  input  logic [POS_W-1:0] pos_y,
  output logic             empty,
  output win_acc_t         acc
);

  localparam logic [CW-1:0] RAD_C   = CW'(STAMP_RADIUS);
  localparam logic [CW-1:0] WIDTH_C = CW'(GRID_WIDTH);
  localparam logic [CW-1:0] HEIGHT_C = CW'(GRID_HEIGHT);
  localparam logic [GAW-1:0] ROW_STEP = GAW'(GRID_WIDTH);
  localparam logic [SAW-1:0] SROW_STEP = SAW'(STAMP_SIDE);

  logic           active_r, active_nxt;
  logic [CW-1:0]  cx_r, cx_nxt;
  logic [CW-1:0]  cy_r, cy_nxt;
  logic [CW-1:0]  x_lo_r, x_lo_nxt;
  logic [CW-1:0]  x_last_r, x_last_nxt;
  logic [CW-1:0]  y_last_r, y_last_nxt;
  logic [SCW-1:0] sc_r, sc_nxt;
  logic [SCW-1:0] sc0_r, sc0_nxt;
  logic [GAW-1:0] grow_r, grow_nxt;
  logic [SAW-1:0] srow_r, srow_nxt;

  logic [CW-1:0]  xe, ye, x_lo, x_hi, y_lo, y_hi;
  logic [SCW-1:0] sc0, sr0;
  logic           row_end, col_end;

  always_comb begin
    xe   = CW'(pos_x);
    ye   = CW'(pos_y);
    x_lo = (xe >= RAD_C) ? xe - RAD_C : '0;
    y_lo = (ye >= RAD_C) ? ye - RAD_C : '0;
    x_hi = (xe + RAD_C > WIDTH_C) ? WIDTH_C : xe + RAD_C;
    y_hi = (ye + RAD_C > HEIGHT_C) ? HEIGHT_C : ye + RAD_C;
    empty = (x_lo >= x_hi) || (y_lo >= y_hi);
    sc0  = SCW'(x_lo + RAD_C - xe);
    sr0  = SCW'(y_lo + RAD_C - ye);
  end

  assign col_end = (cx_r == x_last_r);
  assign row_end = (cy_r == y_last_r);

  always_comb begin
    active_nxt = active_r;
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    x_lo_nxt   = x_lo_r;
    x_last_nxt = x_last_r;
    y_last_nxt = y_last_r;
    sc_nxt     = sc_r;
    sc0_nxt    = sc0_r;
    grow_nxt   = grow_r;
    srow_nxt   = srow_r;
    if (start) begin
      active_nxt = !empty;
      cx_nxt     = x_lo;
      cy_nxt     = y_lo;
      x_lo_nxt   = x_lo;
      x_last_nxt = x_hi - CW'(1);
      y_last_nxt = y_hi - CW'(1);
      sc_nxt     = sc0;
      sc0_nxt    = sc0;
      grow_nxt   = GAW'(int'(y_lo) * GRID_WIDTH);
      srow_nxt   = SAW'(int'(sr0) * STAMP_SIDE);
    end else if (active_r) begin
      if (col_end) begin
        // wrap to the next row of the window
        cx_nxt   = x_lo_r;
        sc_nxt   = sc0_r;
        cy_nxt   = cy_r + CW'(1);
        grow_nxt = grow_r + ROW_STEP;
        srow_nxt = srow_r + SROW_STEP;
        if (row_end) begin
          active_nxt = 1'b0;
        end
      end else begin
        cx_nxt = cx_r + CW'(1);
        sc_nxt = sc_r + SCW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cx_r     <= cx_nxt;
    cy_r     <= cy_nxt;
    x_lo_r   <= x_lo_nxt;
    x_last_r <= x_last_nxt;
    y_last_r <= y_last_nxt;
    sc_r     <= sc_nxt;
    sc0_r    <= sc0_nxt;
    grow_r   <= grow_nxt;
    srow_r   <= srow_nxt;
  end

  assign acc.valid = active_r;
  assign acc.last  = col_end && row_end;
  assign acc.gaddr = grow_r + GAW'(cx_r);
  assign acc.saddr = srow_r + SAW'(sc_r);

endmodule

// ----- rtl/kernel_splat_accumulator.sv -----
// Kernel splat accumulator top level: grid and stamp memories, command sequencer
// and result register. Depends on ksa_pkg and ksa_window.
//
// Usage: commands arrive as beats on the in_ channel (kind in in_tuser), and every
// command gives exactly one result beat on the out_ channel.
//   clear grid : zeroes the grid, one cell per cycle.
//   load stamp : writes one stamp byte (ignored beyond the stamp side).
//   add point  : read-modify-write of each clipped window cell, one cell per cycle
//                through the single grid read port and one write port.
//                A dead point or an empty window writes nothing.
//   read cell  : one registered memory read; cells off the grid read 0.
// A command is taken only while the sequencer is idle; the result register lets
// the next command start while a result still waits on out_tready. If that result
// is still held when the next one completes, the sequencer holds until it is taken.
// After reset both memories are swept to zero over SWEEP_CELLS addresses;
// in_tready stays low during the sweep and no result is produced.

module kernel_splat_accumulator import ksa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [7:0] pos_x, [15:8] pos_y, [20:16] stamp_col, [25:21] stamp_row,
  // [33:26] stamp_value, [39:34] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [1:0] cmd, [2] alive
  input  logic [IN_USER_W-1:0]  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [7:0] cell_value
  output logic [OUT_DATA_W-1:0] out_tdata,
  // [0] is_read
  output logic [OUT_USER_W-1:0] out_tuser
);

  // Input fields
  logic [POS_W-1:0]  pos_x, pos_y;
  logic [SIDX_W-1:0] stamp_col, stamp_row;
  logic [VAL_W-1:0]  stamp_value;
  cmd_t              cmd;
  logic              alive;

  assign pos_x       = in_tdata[7:0];
  assign pos_y       = in_tdata[15:8];
  assign stamp_col   = in_tdata[20:16];
  assign stamp_row   = in_tdata[25:21];
  assign stamp_value = in_tdata[33:26];
  assign cmd         = cmd_t'(in_tuser[1:0]);
  assign alive       = in_tuser[2];

  // Control and payload registers
  state_t          state_r, state_nxt;
  logic [SWW-1:0]  cnt_r, cnt_nxt;
  logic            out_tvalid_r, out_tvalid_nxt;
  logic [VAL_W-1:0] out_data_r, out_data_nxt;
  logic            out_read_r, out_read_nxt;
  logic [VAL_W-1:0] res_val_r, res_val_nxt;
  logic            res_read_r, res_read_nxt;
  logic            rd_ok_r, rd_ok_nxt;
  logic            wr_en_r;
  logic [GAW-1:0]  wr_addr_r;

  logic            accept, win_start, win_empty;
  win_acc_t        acc;
  logic            sweeping, load_ok, rd_in_range;
  logic [GAW-1:0]  rd_addr;

  // Memories
  logic [VAL_W-1:0] grid_mem [GRID_CELLS];
  logic [VAL_W-1:0] stamp_mem [STAMP_CELLS];
  logic [VAL_W-1:0] grid_q, stamp_q;
  logic             grid_we, stamp_we;
  logic [GAW-1:0]   grid_waddr, grid_raddr;
  logic [SAW-1:0]   stamp_waddr;
  logic [VAL_W-1:0] grid_wdata, stamp_wdata;

  ksa_window u_window (
    .clk   (clk),
    .rst_n (rst_n),
    .start (win_start),
    .pos_x (pos_x),
    .pos_y (pos_y),
    .empty (win_empty),
    .acc   (acc)
  );

  assign in_tready   = (state_r == ST_IDLE);
  assign accept      = in_tvalid && in_tready;
  assign rd_in_range = (int'(pos_x) < GRID_WIDTH) && (int'(pos_y) < GRID_HEIGHT);
  assign rd_addr     = GAW'(int'(pos_y) * GRID_WIDTH + int'(pos_x));
  assign load_ok     = (int'(stamp_col) < STAMP_SIDE) && (int'(stamp_row) < STAMP_SIDE);
  assign sweeping    = (state_r == ST_INIT) || (state_r == ST_CLEAR);

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    out_tvalid_nxt = out_tvalid_r;
    out_data_nxt   = out_data_r;
    out_read_nxt   = out_read_r;
    res_val_nxt    = res_val_r;
    res_read_nxt   = res_read_r;
    rd_ok_nxt      = rd_ok_r;
    win_start      = 1'b0;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_INIT: begin
        cnt_nxt = cnt_r + SWW'(1);
        if (int'(cnt_r) == SWEEP_CELLS - 1) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        cnt_nxt = cnt_r + SWW'(1);
        if (int'(cnt_r) == GRID_CELLS - 1) begin
          cnt_nxt   = '0;
          state_nxt = ST_DONE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          res_val_nxt  = '0;
          res_read_nxt = 1'b0;
          unique case (cmd)
            CMD_CLEAR: state_nxt = ST_CLEAR;
            CMD_LOAD:  state_nxt = ST_DONE;
            CMD_ADD: begin
              if (alive && !win_empty) begin
                win_start = 1'b1;
                state_nxt = ST_SPLAT;
              end else begin
                state_nxt = ST_DONE;
              end
            end
            CMD_READ: begin
              res_read_nxt = 1'b1;
              rd_ok_nxt    = rd_in_range;
              state_nxt    = ST_READ;
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_SPLAT: begin
        // the last write-back is registered (wr_en_r) and lands while in ST_DONE
        if (acc.valid && acc.last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_READ: begin
        res_val_nxt = rd_ok_r ? grid_q : '0;
        state_nxt   = ST_DONE;
      end
      ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_data_nxt   = res_val_r;
          out_read_nxt   = res_read_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_INIT;
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
      wr_en_r      <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      wr_en_r      <= (state_r == ST_SPLAT) && acc.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_read_r <= out_read_nxt;
    res_val_r  <= res_val_nxt;
    res_read_r <= res_read_nxt;
    rd_ok_r    <= rd_ok_nxt;
    wr_addr_r  <= acc.gaddr;
  end

  // Grid port control: sweep writes zeros, splat writes back the sum in the cycle after the read
  always_comb begin
    grid_we    = (sweeping && (int'(cnt_r) < GRID_CELLS)) || wr_en_r;
    grid_waddr = sweeping ? GAW'(cnt_r) : wr_addr_r;
    grid_wdata = sweeping ? '0 : grid_q + stamp_q;
    grid_raddr = (state_r == ST_SPLAT) ? acc.gaddr : rd_addr;
  end

  always_comb begin
    stamp_we    = ((state_r == ST_INIT) && (int'(cnt_r) < STAMP_CELLS))
                  || (accept && (cmd == CMD_LOAD) && load_ok);
    stamp_waddr = (state_r == ST_INIT) ? SAW'(cnt_r)
                  : SAW'(int'(stamp_row) * STAMP_SIDE + int'(stamp_col));
    stamp_wdata = (state_r == ST_INIT) ? '0 : stamp_value;
  end

  always_ff @(posedge clk) begin
    if (grid_we) begin
      grid_mem[grid_waddr] <= grid_wdata;
    end
    grid_q <= grid_mem[grid_raddr];
  end

  always_ff @(posedge clk) begin
    if (stamp_we) begin
      stamp_mem[stamp_waddr] <= stamp_wdata;
    end
    stamp_q <= stamp_mem[acc.saddr];
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_read_r;

endmodule
